[rtl/core/twcw_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text window character writer package
// Shared screen geometry, command and register codes, and the structures
// passed between the top level and the step logic.
// ----------------------------------------------------------------------------
package twcw_pkg;

  // Screen geometry in character cells.
  localparam int SCREEN_COLS = 80;
  localparam int SCREEN_ROWS = 25;

  // Command codes of an input item.
  localparam logic [1:0] CMD_PUT  = 2'd0;
  localparam logic [1:0] CMD_FILL = 2'd1;
  localparam logic [1:0] CMD_SET  = 2'd2;

  // Character codes with a special meaning.
  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_SPACE   = 8'd32;

  // Configuration register indexes.
  localparam logic [2:0] REG_TOP_ROW  = 3'd0;
  localparam logic [2:0] REG_LEFT_COL = 3'd1;
  localparam logic [2:0] REG_WIDTH    = 3'd2;
  localparam logic [2:0] REG_HEIGHT   = 3'd3;
  localparam logic [2:0] REG_WRAP     = 3'd4;
  localparam logic [2:0] REG_ATTR     = 3'd5;

  typedef struct packed {
    logic [4:0] window_top_row;
    logic [6:0] window_left_col;
    logic [6:0] window_width;
    logic [4:0] window_height;
    logic       wrap_mode;
    logic [7:0] text_attr;
  } twcw_cfg_t;

  typedef struct packed {
    logic [6:0] new_col;
    logic [4:0] new_row;
    logic [7:0] char_code;
    logic [1:0] command;
  } twcw_item_t;

  typedef struct packed {
    logic [4:0] row;
    logic [6:0] col;
  } twcw_cursor_t;

  // Field order matches the packing of out_tdata, lowest field last here.
  typedef struct packed {
    logic [6:0]  run_length;
    logic [7:0]  cell_attr;
    logic [7:0]  cell_char;
    logic [10:0] cell_index;
  } twcw_cell_t;

endpackage

[rtl/core/twcw_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text window character writer step logic
// Decodes one item against the cursor and window setup, giving the next
// cursor and at most one cell run write.
// ----------------------------------------------------------------------------
module twcw_step (
  input  twcw_pkg::twcw_item_t   item,
  input  twcw_pkg::twcw_cursor_t cursor,
  input  twcw_pkg::twcw_cfg_t    cfg,
  output twcw_pkg::twcw_cursor_t cursor_nxt,
  output logic                   cell_valid,
  output twcw_pkg::twcw_cell_t   wr_cell
);

  logic [4:0] rows;
  logic [6:0] cols;
  logic       below;
  logic [4:0] row_inc;
  logic       want_write;
  logic [4:0] sel_row;
  logic [6:0] sel_col;
  logic [6:0] sel_len;
  logic [7:0] sel_char;
  logic [5:0] srow;
  logic [7:0] scol;
  logic [7:0] room;
  logic       on_screen;

  // Interior size; a window narrower than its borders has no interior.
  assign rows    = (cfg.window_height >= 5'd2) ? cfg.window_height - 5'd2 : 5'd0;
  assign cols    = (cfg.window_width >= 7'd2) ? cfg.window_width - 7'd2 : 7'd0;
  assign below   = (cursor.row >= rows);
  assign row_inc = cursor.row + 5'd1;

  always_comb begin
    cursor_nxt = cursor;
    want_write = 1'b0;
    sel_row    = cursor.row;
    sel_col    = cursor.col;
    sel_len    = 7'd1;
    sel_char   = item.char_code;
    case (item.command)
      twcw_pkg::CMD_PUT: begin
        if (!below) begin
          if (item.char_code == twcw_pkg::CH_NEWLINE) begin
            cursor_nxt.row = row_inc;
            cursor_nxt.col = 7'd0;
          end else if (cursor.col < cols) begin
            want_write     = 1'b1;
            cursor_nxt.col = cursor.col + 7'd1;
          end else if (cfg.wrap_mode) begin
            // Wrap to the next row, but only write if it is still inside.
            cursor_nxt.row = row_inc;
            cursor_nxt.col = 7'd1;
            sel_row        = row_inc;
            sel_col        = 7'd0;
            want_write     = (row_inc < rows);
          end
        end
      end
      twcw_pkg::CMD_FILL: begin
        if (!below && (cursor.col < cols)) begin
          want_write     = 1'b1;
          sel_len        = cols - cursor.col;
          sel_char       = twcw_pkg::CH_SPACE;
          cursor_nxt.col = cols;
        end
      end
      twcw_pkg::CMD_SET: begin
        cursor_nxt.row = item.new_row;
        cursor_nxt.col = item.new_col;
      end
      default: begin
      end
    endcase
  end

  // Screen position of the first cell, past the top and left borders.
  assign srow = 6'(cfg.window_top_row) + 6'(sel_row) + 6'd1;
  assign scol = 8'(cfg.window_left_col) + 8'(sel_col) + 8'd1;
  assign on_screen = (srow < 6'(twcw_pkg::SCREEN_ROWS)) &&
                     (scol < 8'(twcw_pkg::SCREEN_COLS));
  assign room = 8'(twcw_pkg::SCREEN_COLS) - scol;

  assign cell_valid         = want_write && on_screen;
  assign wr_cell.cell_index = 11'(srow) * 11'(twcw_pkg::SCREEN_COLS) + 11'(scol);
  assign wr_cell.cell_char  = sel_char;
  assign wr_cell.cell_attr  = cfg.text_attr;
  // A run that crosses the right screen edge is clipped there.
  assign wr_cell.run_length = (8'(sel_len) > room) ? room[6:0] : sel_len;

endmodule

[rtl/core/text_window_char_writer_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text window character writer
// Turns a stream of put, fill and set-cursor commands into cell run writes
// for a bordered window on an 80 by 25 character text screen.
// ----------------------------------------------------------------------------
// The block takes one command transfer per clock cycle while in_tready is
// high and answers each with zero or one registered cell write transfer.
// The rate is set by the cursor registers: each command reads and updates
// the cursor in the cycle it is taken, through a single pass of decode, a
// few narrow adds and a constant multiply for the cell index. A two-entry
// output buffer (result register plus skid register) lets the input keep
// flowing while the consumer stalls; in_tready drops only when both entries
// hold results. Configuration writes take effect at once and should be made
// only while no command is in flight.
module text_window_char_writer_top (
  input  logic        clk,
  input  logic        rst_n,
  // Input commands.
  input  logic        in_tvalid,
  output logic        in_tready,
  // in_tdata fields from bit 0 up: command[1:0], char_code[9:2],
  // new_row[14:10], new_col[21:15], zero fill[23:22].
  input  logic [23:0] in_tdata,
  // Cell write results.
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_tdata fields from bit 0 up: cell_index[10:0], cell_char[18:11],
  // cell_attr[26:19], run_length[33:27], zero fill[39:34].
  output logic [39:0] out_tdata,
  // Configuration write port.
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [7:0]  cfg_wdata
);

  twcw_pkg::twcw_cfg_t    cfg_r;
  twcw_pkg::twcw_cursor_t cursor_r;
  twcw_pkg::twcw_cursor_t cursor_nxt;
  twcw_pkg::twcw_item_t   item;
  twcw_pkg::twcw_cell_t   wr_cell;
  twcw_pkg::twcw_cell_t   out_cell_r;
  twcw_pkg::twcw_cell_t   skid_cell_r;
  logic                   cell_valid;
  logic                   out_valid_r;
  logic                   skid_valid_r;
  logic                   in_xfer;
  logic                   out_xfer;
  logic                   push;

  assign item      = twcw_pkg::twcw_item_t'(in_tdata[21:0]);
  assign in_tready = !skid_valid_r;
  assign in_xfer   = in_tvalid && in_tready;
  assign out_xfer  = out_valid_r && out_tready;
  assign push      = in_xfer && cell_valid;

  twcw_step u_step (
    .item       (item),
    .cursor     (cursor_r),
    .cfg        (cfg_r),
    .cursor_nxt (cursor_nxt),
    .cell_valid (cell_valid),
    .wr_cell    (wr_cell)
  );

  // Configuration registers; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window_top_row  <= 5'd0;
      cfg_r.window_left_col <= 7'd0;
      cfg_r.window_width    <= 7'd80;
      cfg_r.window_height   <= 5'd25;
      cfg_r.wrap_mode       <= 1'b0;
      cfg_r.text_attr       <= 8'd7;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        twcw_pkg::REG_TOP_ROW:  cfg_r.window_top_row  <= cfg_wdata[4:0];
        twcw_pkg::REG_LEFT_COL: cfg_r.window_left_col <= cfg_wdata[6:0];
        twcw_pkg::REG_WIDTH:    cfg_r.window_width    <= cfg_wdata[6:0];
        twcw_pkg::REG_HEIGHT:   cfg_r.window_height   <= cfg_wdata[4:0];
        twcw_pkg::REG_WRAP:     cfg_r.wrap_mode       <= cfg_wdata[0];
        twcw_pkg::REG_ATTR:     cfg_r.text_attr       <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // The cursor is updated on every command transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r <= '0;
    end else if (in_xfer) begin
      cursor_r <= cursor_nxt;
    end
  end

  // Two-entry output buffer. A new result goes to the result register when
  // it is empty or being drained, otherwise to the skid register. While the
  // skid register is full no command is taken, so there is nothing to push.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_xfer) begin
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (out_valid_r && !out_tready) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (out_xfer) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_xfer) begin
        out_cell_r <= skid_cell_r;
      end
    end else if (push) begin
      if (out_valid_r && !out_tready) begin
        skid_cell_r <= wr_cell;
      end else begin
        out_cell_r <= wr_cell;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_cell_r};

  // The skid register only ever holds the younger of two results.
  assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register full while result register empty");

  // Every delivered run covers at least one cell and stays on one row.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_cell_r.run_length != 7'd0) &&
                    (out_cell_r.run_length <= 7'(twcw_pkg::SCREEN_COLS)))
    else $error("run length out of range");

  // The cell index always lands on the screen.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |->
      (out_cell_r.cell_index < 11'(twcw_pkg::SCREEN_COLS * twcw_pkg::SCREEN_ROWS)))
    else $error("cell index past the end of the screen");

  // A set-cursor command loads the cursor as given.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && (item.command == twcw_pkg::CMD_SET)) |=>
      (cursor_r.row == $past(item.new_row)) && (cursor_r.col == $past(item.new_col)))
    else $error("cursor not loaded by set command");

  // Only put and fill commands produce a cell write.
  assert property (@(posedge clk) disable iff (!rst_n)
    push |-> ((item.command == twcw_pkg::CMD_PUT) || (item.command == twcw_pkg::CMD_FILL)))
    else $error("cell write from a command that never writes");

endmodule

[tb/tb_text_window_char_writer_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text window character writer testbench
// Drives put, fill and set-cursor commands into the writer under several
// window settings and checks every cell write against a behavioral model of
// the cursor and window logic kept inside a small scoreboard.
// ----------------------------------------------------------------------------
module tb_text_window_char_writer_top;
  import twcw_pkg::*;

  // --------------------------------------------------------------------------
  // Scoreboard: tracks the window registers and the cursor the same way the
  // block should, and queues the cell write that each accepted command
  // produces. Results leave the block in order, so the oldest queued write is
  // always the one to compare against.
  // --------------------------------------------------------------------------
  class cell_write_scoreboard;
    twcw_cfg_t    cfg;
    twcw_cursor_t cursor;
    twcw_cell_t   queued_writes[$];
    int           errors;

    function new();
      cfg.window_top_row  = 5'd0;
      cfg.window_left_col = 7'd0;
      cfg.window_width    = 7'd80;
      cfg.window_height   = 5'd25;
      cfg.wrap_mode       = 1'b0;
      cfg.text_attr       = 8'd7;
      cursor.row          = 5'd0;
      cursor.col          = 7'd0;
      errors              = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [7:0] val);
      case (idx)
        REG_TOP_ROW:  cfg.window_top_row  = val[4:0];
        REG_LEFT_COL: cfg.window_left_col = val[6:0];
        REG_WIDTH:    cfg.window_width    = val[6:0];
        REG_HEIGHT:   cfg.window_height   = val[4:0];
        REG_WRAP:     cfg.wrap_mode       = val[0];
        REG_ATTR:     cfg.text_attr       = val;
        default: ;
      endcase
    endfunction

    function int interior_rows();
      return (cfg.window_height >= 2) ? int'(cfg.window_height) - 2 : 0;
    endfunction

    function int interior_cols();
      return (cfg.window_width >= 2) ? int'(cfg.window_width) - 2 : 0;
    endfunction

    function int outstanding();
      return queued_writes.size();
    endfunction

    // Queue a run at an interior position unless it lands off the screen.
    function void place_run(int row, int col, logic [7:0] ch, int len);
      twcw_cell_t wr;
      int         srow;
      int         scol;
      srow = int'(cfg.window_top_row) + row + 1;
      scol = int'(cfg.window_left_col) + col + 1;
      if (srow >= SCREEN_ROWS || scol >= SCREEN_COLS) return;
      // A fill that runs past the right screen edge is cut there.
      if (len > SCREEN_COLS - scol) len = SCREEN_COLS - scol;
      wr.cell_index = 11'(srow * SCREEN_COLS + scol);
      wr.cell_char  = ch;
      wr.cell_attr  = cfg.text_attr;
      wr.run_length = 7'(len);
      queued_writes.push_back(wr);
    endfunction

    function void note_input(twcw_item_t it);
      int rows;
      int cols;
      rows = interior_rows();
      cols = interior_cols();
      case (it.command)
        CMD_SET: begin
          // Stored as given, even outside the interior.
          cursor.row = it.new_row;
          cursor.col = it.new_col;
        end
        CMD_FILL: begin
          if (cursor.row < rows && cursor.col < cols) begin
            place_run(cursor.row, cursor.col, CH_SPACE, cols - int'(cursor.col));
            cursor.col = 7'(cols);
          end
        end
        CMD_PUT: begin
          if (cursor.row < rows) begin
            if (it.char_code == CH_NEWLINE) begin
              cursor.col = 7'd0;
              cursor.row = cursor.row + 5'd1;
            end else if (cursor.col < cols) begin
              place_run(cursor.row, cursor.col, it.char_code, 1);
              cursor.col = cursor.col + 7'd1;
            end else if (cfg.wrap_mode) begin
              // Wrap to the next row; nothing is written below the interior,
              // but the column still ends up just past the first cell.
              cursor.row = cursor.row + 5'd1;
              if (cursor.row < rows) place_run(cursor.row, 0, it.char_code, 1);
              cursor.col = 7'd1;
            end
            // In truncate mode a character past the edge is simply dropped.
          end
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_cell(twcw_cell_t got);
      twcw_cell_t want;
      if (queued_writes.size() == 0) begin
        errors++;
        $display("%0t: unexpected cell write, expected none, actual index %0d char %0d attr %0d len %0d",
                 $time, got.cell_index, got.cell_char, got.cell_attr, got.run_length);
        return;
      end
      want = queued_writes.pop_front();
      compare_field("cell_index", want.cell_index, got.cell_index);
      compare_field("cell_char",  want.cell_char,  got.cell_char);
      compare_field("cell_attr",  want.cell_attr,  got.cell_attr);
      compare_field("run_length", want.run_length, got.run_length);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Block connections. Every input starts at a known value.
  // --------------------------------------------------------------------------
  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        cfg_we     = 1'b0;
  logic [2:0]  cfg_addr   = REG_TOP_ROW;
  logic [7:0]  cfg_wdata  = '0;

  text_window_char_writer_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  cell_write_scoreboard sb;

  // Sender burst bookkeeping: how many transfers remain in the current burst.
  int burst_left = 0;

  // Receiver stall pattern state.
  int stall_mode = 0;
  int mode_left  = 0;
  int hold_left  = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs, set well past the slowest correct run
  // so that it leaves plenty of margin.
  initial begin
    #2_000_000;
    $display("tb_text_window_char_writer_top failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side. Outputs are sampled right after the edge, which still shows
  // the values from before it, so a transfer happened when valid and ready
  // were both high. The ready pattern switches between always ready, strict
  // alternation, random stalls and occasional long stalls.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_cell(twcw_cell_t'(out_tdata[33:0]));

    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      mode_left  <= $urandom_range(20, 120);
    end else begin
      mode_left <= mode_left - 1;
    end

    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ~out_tready;
      2: out_tready <= ($urandom_range(0, 9) >= 3);
      default: begin
        if (hold_left != 0) begin
          hold_left  <= hold_left - 1;
          out_tready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
          hold_left  <= $urandom_range(2, 8);
          out_tready <= 1'b0;
        end else begin
          out_tready <= 1'b1;
        end
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Command side.
  // --------------------------------------------------------------------------
  function automatic twcw_item_t make_item(logic [1:0] cmd, logic [7:0] ch,
                                           logic [4:0] row, logic [6:0] col);
    twcw_item_t it;
    it.command   = cmd;
    it.char_code = ch;
    it.new_row   = row;
    it.new_col   = col;
    return it;
  endfunction

  // Present one command and hold it until the block takes the transfer. At
  // the end of a burst valid drops for a random gap; otherwise it stays high
  // so back-to-back transfers are exercised.
  task automatic send_item(input twcw_item_t it);
    int gap;
    in_tdata  <= {2'b00, it};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(it);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Let every expected write drain, then keep waiting until a command with no
  // result has surely left the pipeline.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
    cfg_addr  <= idx;
    cfg_wdata <= val;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic set_window(input int top, input int left, input int width,
                            input int height, input int wrap, input int attr);
    write_reg(REG_TOP_ROW,  8'(top));
    write_reg(REG_LEFT_COL, 8'(left));
    write_reg(REG_WIDTH,    8'(width));
    write_reg(REG_HEIGHT,   8'(height));
    write_reg(REG_WRAP,     8'(wrap));
    write_reg(REG_ATTR,     8'(attr));
  endtask

  // Register value that favors the ends of its range.
  function automatic int pick_value(int lo, int hi);
    int r;
    r = $urandom_range(0, 3);
    if (r == 0) return lo;
    if (r == 1) return hi;
    return $urandom_range(lo, hi);
  endfunction

  // Random command shaped for text output: mostly printable characters with
  // newlines, some fills, regular cursor moves back into the window (without
  // them the cursor soon falls below the window and everything is ignored),
  // and a little noise from the unused command code and odd bytes.
  function automatic twcw_item_t random_item();
    twcw_item_t it;
    int         r;
    int         rows;
    int         cols;
    rows = sb.interior_rows();
    cols = sb.interior_cols();
    it = make_item(CMD_PUT, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 24)),
                   7'($urandom_range(0, 79)));
    r = $urandom_range(0, 99);
    if (r < 6) begin
      it.command = CMD_SET;
      it.new_row = ($urandom_range(0, 6) == 0) ? 5'($urandom_range(0, 24))
                                               : 5'($urandom_range(0, rows - 1));
      it.new_col = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(0, 79))
                                               : 7'($urandom_range(0, cols));
    end else if (r < 11) begin
      it.command = CMD_FILL;
    end else if (r < 12) begin
      it.command = 2'd3;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 8) it.char_code = CH_NEWLINE;
      else if (r >= 20) it.char_code = 8'($urandom_range(32, 126));
    end
    return it;
  endfunction

  initial begin
    int phase;
    int n;

    sb = new();

    // Synchronous reset held at the start, then released for good.
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed checks with the reset window: the full 78 by 23 interior.
    send_item(make_item(CMD_PUT,  8'h41, 5'd0, 7'd0));   // first interior cell
    send_item(make_item(CMD_PUT,  8'h00, 5'd0, 7'd0));   // lowest character byte
    send_item(make_item(CMD_PUT,  8'hFF, 5'd24, 7'd79)); // highest byte, unused fields at max
    send_item(make_item(CMD_PUT,  CH_NEWLINE, 5'd0, 7'd0));
    send_item(make_item(CMD_FILL, 8'h00, 5'd0, 7'd0));   // longest possible run
    send_item(make_item(CMD_PUT,  8'h78, 5'd0, 7'd0));   // truncated at right edge
    send_item(make_item(2'd3,     8'h41, 5'd1, 7'd1));   // unused command, ignored
    send_item(make_item(CMD_SET,  8'h00, 5'd22, 7'd77)); // last interior cell
    send_item(make_item(CMD_PUT,  8'h5A, 5'd0, 7'd0));
    send_item(make_item(CMD_PUT,  8'h5A, 5'd0, 7'd0));   // dropped, column holds
    send_item(make_item(CMD_SET,  8'h00, 5'd23, 7'd0));  // first row below the window
    send_item(make_item(CMD_PUT,  8'h51, 5'd0, 7'd0));   // no write below the window
    send_item(make_item(CMD_FILL, 8'h00, 5'd0, 7'd0));
    wait_idle();

    // Wrap mode: a character past the edge moves to the next row, but never
    // writes below the window.
    write_reg(REG_WRAP, 8'd1);
    write_reg(REG_ATTR, 8'hFF);
    send_item(make_item(CMD_SET, 8'h00, 5'd0, 7'd77));
    send_item(make_item(CMD_PUT, 8'h61, 5'd0, 7'd0));
    send_item(make_item(CMD_PUT, 8'h62, 5'd0, 7'd0));    // wraps to next row
    send_item(make_item(CMD_SET, 8'h00, 5'd22, 7'd78));
    send_item(make_item(CMD_PUT, 8'h63, 5'd0, 7'd0));    // wrap lands below window
    wait_idle();

    // Window hanging off the bottom right of the screen: fills are clipped
    // at the screen edge and writes beyond it are dropped.
    set_window(20, 70, 20, 5, 0, 0);
    send_item(make_item(CMD_SET,  8'h00, 5'd0, 7'd0));
    send_item(make_item(CMD_FILL, 8'h00, 5'd0, 7'd0));
    send_item(make_item(CMD_SET,  8'h00, 5'd1, 7'd9));
    send_item(make_item(CMD_PUT,  8'h64, 5'd0, 7'd0));   // off screen, cursor still moves
    wait_idle();

    // Smallest window in the bottom right corner: its only row is off screen.
    set_window(24, 79, 3, 3, 1, 128);
    send_item(make_item(CMD_SET, 8'h00, 5'd0, 7'd0));
    send_item(make_item(CMD_PUT, 8'h65, 5'd0, 7'd0));
    wait_idle();

    // Random phases. The first two pin the register extremes; the rest mix
    // random and extreme values, so windows often reach past the screen.
    for (phase = 0; phase < 8; phase++) begin
      if (phase == 0) set_window(0, 0, 80, 25, 1, 255);
      else if (phase == 1) set_window(0, 0, 3, 3, 0, 0);
      else set_window(pick_value(0, 24), pick_value(0, 79), pick_value(3, 80),
                      pick_value(3, 25), $urandom_range(0, 1), pick_value(0, 255));
      send_item(make_item(CMD_SET, 8'h00, 5'd0, 7'd0));
      n = 0;
      while (n < 145) begin
        send_item(random_item());
        n++;
      end
      wait_idle();
    end

    // Everything sent has drained; a final wait catches stray writes.
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("tb_text_window_char_writer_top passed");
    end else begin
      $display("tb_text_window_char_writer_top failed");
    end
    $finish;
  end

endmodule
